// ----- rtl/core/fsus_pkg.sv -----
// shared constants and types for the first unique symbol stream block
package fsus_pkg;

   localparam int ALPHABET = 26;
   localparam int LETTER_W = 5;
   localparam int CNT_W    = $clog2(ALPHABET + 1);

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [CNT_W-1:0]    count_type;

   typedef struct packed {
      logic step;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_EMPTY = 2'b01,
      ST_FULL  = 2'b10
   } state_type;

endpackage

// ----- rtl/core/fsus_ctrl.sv -----
// handshake controller: request acceptance and result register occupancy
module fsus_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output fsus_pkg::cmd_type cmd
);
   import fsus_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_EMPTY) || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_FULL);
   assign cmd.step   = accept;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (accept) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (accept) state_in = ST_FULL;
            else if (rsp_tready) state_in = ST_EMPTY;
         end
         default: begin
            state_in = ST_EMPTY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/fsus_datapath.sv -----
// seen flags, ordered queue cells with parallel compare, and result register
module fsus_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  fsus_pkg::cmd_type    cmd,
   input  fsus_pkg::letter_type letter,
   input  logic                 new_stream,
   output logic                 found,
   output fsus_pkg::letter_type first_unique
);
   import fsus_pkg::*;

   logic [ALPHABET-1:0] seen_ff;
   logic [ALPHABET-1:0] seen_in;
   letter_type          queue_ff [ALPHABET];
   letter_type          queue_in [ALPHABET];
   count_type           count_ff;
   count_type           count_in;
   logic                found_ff;
   letter_type          symbol_ff;

   logic [ALPHABET-1:0] seen_base;
   count_type           count_base;
   logic [ALPHABET-1:0] sel;
   logic [ALPHABET-1:0] match;
   logic [ALPHABET-1:0] shift;
   logic                in_range;
   logic                was_seen;

   always_comb begin
      seen_base  = new_stream ? '0 : seen_ff;
      count_base = new_stream ? '0 : count_ff;
      in_range   = (int'(letter) < ALPHABET);
      for (int i = 0; i < ALPHABET; i++) begin
         sel[i]   = (int'(letter) == i);
         match[i] = (CNT_W'(i) < count_base) && (queue_ff[i] == letter);
      end
      was_seen = |(seen_base & sel);

      // cells at or after the removed letter close up the gap
      shift[0] = match[0];
      for (int i = 1; i < ALPHABET; i++) begin
         shift[i] = shift[i-1] | match[i];
      end

      seen_in  = seen_base;
      count_in = count_base;
      for (int i = 0; i < ALPHABET; i++) begin
         queue_in[i] = queue_ff[i];
      end

      if (in_range && !was_seen) begin
         seen_in = seen_base | sel;
         if (int'(count_base) < ALPHABET) begin
            for (int i = 0; i < ALPHABET; i++) begin
               if (CNT_W'(i) == count_base) queue_in[i] = letter;
            end
            count_in = count_base + 1'b1;
         end
      end else if (in_range) begin
         for (int i = 0; i < ALPHABET - 1; i++) begin
            if (shift[i]) queue_in[i] = queue_ff[i+1];
         end
         if (shift[ALPHABET-1]) queue_in[ALPHABET-1] = '0;
         if (|match) count_in = count_base - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.step) begin
         seen_ff  <= seen_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         for (int i = 0; i < ALPHABET; i++) begin
            queue_ff[i] <= queue_in[i];
         end
         found_ff  <= (count_in != '0);
         symbol_ff <= (count_in != '0) ? queue_in[0] : '0;
      end
   end

   assign found        = found_ff;
   assign first_unique = symbol_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= ALPHABET)
      else $error("queue count beyond alphabet size");

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("letter present more than once in queue");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (found_ff == (count_ff != '0)))
      else $error("found flag disagrees with queue count");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (found_ff || (symbol_ff == '0)))
      else $error("symbol not zero while none found");

endmodule

// ----- rtl/core/first_unique_symbol_stream.sv -----
// top level of the first unique symbol stream block
//
// each request carries one letter index and a new-stream flag; each request
// yields exactly one result: the oldest letter seen exactly once so far in
// the current stream, with a found flag.
// request channel: req_tdata holds the letter index, req_tuser the
// new-stream flag, which clears the seen flags and queue before its letter.
// result channel: rsp_tdata holds the first unique letter (zero when none),
// rsp_tuser the found flag.
// rsp_tvalid rises in the cycle after request acceptance.
// throughput: one request per cycle while the receiver takes the results, set
// by the queue update where all queue cells compare against the letter in parallel.
// reset clears the seen flags, the queue count and the result valid flag.
// when the receiver stalls the result is held and a new request is taken
// only in the cycle the held result is taken.
module first_unique_symbol_stream (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [4:0] letter, [7:5] zero
   input  logic       req_tuser,  // [0] new_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [4:0] first_unique, [7:5] zero
   output logic       rsp_tuser   // [0] found
);
   import fsus_pkg::*;

   cmd_type    cmd;
   letter_type symbol;

   fsus_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fsus_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .letter       (req_tdata[LETTER_W-1:0]),
      .new_stream   (req_tuser),
      .found        (rsp_tuser),
      .first_unique (symbol)
   );

   assign rsp_tdata = {{(8 - LETTER_W){1'b0}}, symbol};

endmodule

// ----- dv/fsus_checker.sv -----
`timescale 1ns / 1ps
// checker that predicts the oldest once-seen letter per request and compares each result
module fsus_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,  // [4:0] letter, [7:5] zero
   input  logic       req_tuser,  // [0] new_stream
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,  // [4:0] first_unique, [7:5] zero
   input  logic       rsp_tuser,  // [0] found
   output int         fail_count,
   output int         pending
);
   import fsus_pkg::*;

   typedef struct {
      logic       found;
      letter_type first_unique;
   } head_type;

   head_type            expected_heads [$];
   logic [ALPHABET-1:0] seen_letters;
   letter_type          unique_order [ALPHABET];
   int                  unique_count;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic clear_letters();
      int k;
      seen_letters = '0;
      for (k = 0; k < ALPHABET; k++) begin
         unique_order[k] = '0;
      end
      unique_count = 0;
   endtask

   task automatic predict_head(input letter_type letter, input logic restart);
      head_type head;
      int       k;
      int       w;
      if (restart) begin
         clear_letters();
      end
      if (letter < ALPHABET) begin
         if (!seen_letters[letter]) begin
            seen_letters[letter] = 1'b1;
            if (unique_count < ALPHABET) begin
               unique_order[unique_count] = letter;
               unique_count++;
            end
         end else begin
            // drop the letter and close up the gap
            w = 0;
            for (k = 0; k < unique_count; k++) begin
               if (unique_order[k] != letter) begin
                  unique_order[w] = unique_order[k];
                  w++;
               end
            end
            for (k = w; k < unique_count; k++) begin
               unique_order[k] = '0;
            end
            unique_count = w;
         end
      end
      head.found        = (unique_count > 0);
      head.first_unique = head.found ? unique_order[0] : '0;
      expected_heads.push_back(head);
   endtask

   always @(posedge clock) begin
      head_type want;
      if (reset) begin
         clear_letters();
         expected_heads.delete();
         fail_count = 0;
      end else begin
         // results first: a result never belongs to a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_heads.size() == 0) begin
               report_mismatch($sformatf("result with none expected: found %0d letter %0d",
                                         rsp_tuser, rsp_tdata[LETTER_W-1:0]));
            end else begin
               want = expected_heads.pop_front();
               if (rsp_tuser !== want.found) begin
                  report_mismatch($sformatf("found: got %0d, expected %0d",
                                            rsp_tuser, want.found));
               end
               if (rsp_tdata[LETTER_W-1:0] !== want.first_unique) begin
                  report_mismatch($sformatf("first_unique: got %0d, expected %0d",
                                            rsp_tdata[LETTER_W-1:0], want.first_unique));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_head(letter_type'(req_tdata[LETTER_W-1:0]), req_tuser);
         end
      end
      pending <= expected_heads.size();
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// testbench top that drives letter requests and result backpressure and prints the verdict
module tb;
   import fsus_pkg::*;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       req_tuser  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   int         fail_count;
   int         pending;
   int         send_gap_pct = 0;
   int         stall_pct    = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   first_unique_symbol_stream DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   fsus_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   task automatic send_letter(input letter_type letter, input logic restart);
      @(negedge clock);
      if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, letter};
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // result side backpressure
   initial begin
      forever begin
         @(negedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      letter_type perm [ALPHABET];
      letter_type letter;
      letter_type tmp;
      int         sent;
      int         mode;
      int         len;
      int         base;
      int         span;
      int         i;
      int         j;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_letter(5'd31, 1'b0);  // ignored letter on an empty queue
      send_letter(5'd0,  1'b0);
      send_letter(5'd1,  1'b0);
      send_letter(5'd0,  1'b0);  // second sighting of the head
      send_letter(5'd1,  1'b0);  // queue empty again
      send_letter(5'd0,  1'b0);  // third sighting
      send_letter(5'd25, 1'b0);
      send_letter(5'd26, 1'b0);
      send_letter(5'd2,  1'b0);
      send_letter(5'd25, 1'b0);
      send_letter(5'd7,  1'b1);  // new stream
      send_letter(5'd7,  1'b0);
      send_letter(5'd30, 1'b1);  // clear with an ignored letter
      send_letter(5'd21, 1'b0);
      send_letter(5'd10, 1'b0);
      send_letter(5'd3,  1'b0);
      send_letter(5'd10, 1'b0);  // removal from the middle
      send_letter(5'd31, 1'b1);
      drain_results();

      sent = 0;
      while (sent < 700) begin
         if (sent >= 600 || $urandom_range(0, 3) == 0) begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end else begin
            send_gap_pct = $urandom_range(5, 40);
            stall_pct    = $urandom_range(5, 40);
         end
         mode = $urandom_range(0, 5);
         if (mode == 0) begin
            // every letter once fills the queue, then repeats drain it
            for (i = 0; i < ALPHABET; i++) begin
               perm[i] = letter_type'(i);
            end
            for (i = ALPHABET - 1; i > 0; i--) begin
               j       = $urandom_range(0, i);
               tmp     = perm[i];
               perm[i] = perm[j];
               perm[j] = tmp;
            end
            for (i = 0; i < ALPHABET; i++) begin
               send_letter(perm[i], i == 0);
            end
            len = $urandom_range(1, 30);
            for (i = 0; i < len; i++) begin
               send_letter(perm[$urandom_range(0, ALPHABET - 1)], 1'b0);
            end
            sent += ALPHABET + len;
         end else if (mode == 5) begin
            // noise over the whole field
            len = $urandom_range(3, 15);
            for (i = 0; i < len; i++) begin
               send_letter(letter_type'($urandom_range(0, 31)), $urandom_range(0, 7) == 0);
            end
            sent += len;
         end else begin
            base = $urandom_range(0, ALPHABET - 1);
            span = $urandom_range(1, ALPHABET);
            len  = $urandom_range(2, 40);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 19) == 0) begin
                  letter = letter_type'($urandom_range(ALPHABET, 31));
               end else begin
                  letter = letter_type'((base + $urandom_range(0, span - 1)) % ALPHABET);
               end
               send_letter(letter, i == 0 && $urandom_range(0, 4) != 0);
            end
            sent += len;
         end
         if ($urandom_range(0, 15) == 0) begin
            drain_results();
         end
      end

      drain_results();
      repeat (4) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
